@@ rtl/knn_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor distance core.
// No dependencies; imported by every module of the block.
package knn_pkg;

   localparam int NEIGHBOURS = 8;    // list length, 1 to 64
   localparam int MAX_PIXELS = 1024; // expected image length, not counted

   localparam int PIXEL_W    = 8;
   localparam int LABEL_W    = 8;
   localparam int RANK_W     = 6;
   localparam int ACC_W      = 27;
   localparam int OUT_DIST_W = 26;
   localparam int SQ_W       = 2 * PIXEL_W;
   localparam int SLOT_W     = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

   localparam int REQ_DATA_W = 3 * 8;                       // 24 bits, whole bytes
   localparam int RSP_DATA_W = RANK_W + OUT_DIST_W + LABEL_W; // 40 bits, whole bytes

   localparam logic [ACC_W-1:0]      ACC_MAX      = '1;
   localparam logic [OUT_DIST_W-1:0] OUT_DIST_MAX = '1;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_EMIT
   } knn_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;   // input beat accepted this cycle
      logic shift;  // load head of list into output register, shift list up
   } knn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;   // output register empty or being taken
      logic last_rank;  // next shift emits the last rank
   } knn_status_type;

endpackage

@@ rtl/knn_distance_topk_core.sv @@
// Top level of the k-nearest-neighbor distance core (squared Euclidean).
// Depends on knn_pkg, knn_ctrl and knn_datapath.
//   The req channel carries one pixel pair per beat: the query pixel and
//   the reference pixel at the same position. req_tlast marks the last
//   pixel of a reference image (its label is sampled on that beat) and
//   req_tuser marks the last pixel of the whole reference set.
//   The squared differences add into a saturating 27-bit distance. Each
//   closed image is offered to a sorted list of NEIGHBOURS entries in the
//   next cycle; a tie goes after the entries already listed.
//   Throughput: one pixel beat per cycle while a set streams in, with no
//   limit on image length. After the set-end beat the req side stalls
//   through the last insertion (ST_FLUSH) and while the results are
//   loaded into the output register (ST_EMIT), longer if the rsp side stalls.
//   Results leave rank 0 first, one per cycle while rsp_tready is high,
//   with rsp_tlast on the last.
//   Unused slots show zero distance and label with rsp_tuser set.
//   The rsp output register holds a beat while rsp_tready is low; the
//   last beat may wait there while the next set already streams in.
//   Reset (synchronous, active high) empties the list, the accumulator
//   and the output register.
module knn_distance_topk_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: query_pixel[7:0], reference_pixel[15:8], reference_label[23:16]
   input  logic [knn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic        req_tlast,  // image_end
   input  logic        req_tuser,  // set_end
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: rank[5:0], neighbour_distance[31:6], neighbour_label[39:32]
   output logic [knn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast,  // last_of_run
   output logic        rsp_tuser,  // slot_empty
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import knn_pkg::*;

   knn_cmd_type    cmd;
   knn_status_type status;

   logic [RANK_W-1:0]     rank;
   logic [OUT_DIST_W-1:0] neighbour_distance;
   logic [LABEL_W-1:0]    neighbour_label;

   knn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   knn_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .query_pixel        (req_tdata[7:0]),
      .reference_pixel    (req_tdata[15:8]),
      .reference_label    (req_tdata[23:16]),
      .image_end          (req_tlast),
      .set_end            (req_tuser),
      .cmd                (cmd),
      .status             (status),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rank               (rank),
      .neighbour_distance (neighbour_distance),
      .neighbour_label    (neighbour_label),
      .slot_empty         (rsp_tuser),
      .last_of_run        (rsp_tlast)
   );

   // pack the result beat, first field in the lowest bits
   assign rsp_tdata = {neighbour_label, neighbour_distance, rank};

endmodule

@@ rtl/knn_ctrl.sv @@
// Controller state machine for the k-nearest-neighbor distance core.
// Depends on knn_pkg.
module knn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tuser,
   output logic                    req_tready,
   output knn_pkg::knn_cmd_type    cmd,
   input  knn_pkg::knn_status_type status
);
   import knn_pkg::*;

   knn_state_type state_ff;
   knn_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid && req_tuser) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.last_rank) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.take   = 1'b0;
      cmd.shift  = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_FLUSH: begin
         end
         ST_EMIT: begin
            cmd.shift = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/knn_datapath.sv @@
// Datapath of the k-nearest-neighbor distance core: accumulator, sorted
// list cells and output register. Depends on knn_pkg.
module knn_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [knn_pkg::PIXEL_W-1:0]    query_pixel,
   input  logic [knn_pkg::PIXEL_W-1:0]    reference_pixel,
   input  logic [knn_pkg::LABEL_W-1:0]    reference_label,
   input  logic                           image_end,
   input  logic                           set_end,
   input  knn_pkg::knn_cmd_type           cmd,
   output knn_pkg::knn_status_type        status,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [knn_pkg::RANK_W-1:0]     rank,
   output logic [knn_pkg::OUT_DIST_W-1:0] neighbour_distance,
   output logic [knn_pkg::LABEL_W-1:0]    neighbour_label,
   output logic                           slot_empty,
   output logic                           last_of_run
);
   import knn_pkg::*;

   // Accumulator and pending offer
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   offer_dist_ff, offer_dist_in;
   logic [LABEL_W-1:0] offer_label_ff, offer_label_in;
   logic               offer_valid_ff, offer_valid_in;

   logic [PIXEL_W:0]   diff;
   logic [PIXEL_W-1:0] abs_diff;
   logic [SQ_W-1:0]    sq;
   logic [ACC_W:0]     sum;
   logic [ACC_W-1:0]   sum_sat;
   logic               close;

   always_comb begin
      diff     = {1'b0, query_pixel} - {1'b0, reference_pixel};
      abs_diff = diff[PIXEL_W] ? PIXEL_W'(-diff) : diff[PIXEL_W-1:0];
      sq       = abs_diff * abs_diff;
      sum      = {1'b0, acc_ff} + (ACC_W + 1)'(sq);
      sum_sat  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
      close    = image_end || set_end;

      acc_in         = acc_ff;
      offer_dist_in  = offer_dist_ff;
      offer_label_in = offer_label_ff;
      offer_valid_in = cmd.take && close;
      if (cmd.take) begin
         acc_in = close ? '0 : sum_sat;
         if (close) begin
            offer_dist_in  = sum_sat;
            offer_label_in = reference_label;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         offer_valid_ff <= 1'b0;
      end else begin
         acc_ff         <= acc_in;
         offer_valid_ff <= offer_valid_in;
      end
      offer_dist_ff  <= offer_dist_in;
      offer_label_ff <= offer_label_in;
   end

   // Sorted list cells, nearest in slot 0
   logic [ACC_W-1:0]   dist_ff  [NEIGHBOURS];
   logic [ACC_W-1:0]   dist_in  [NEIGHBOURS];
   logic [LABEL_W-1:0] label_ff [NEIGHBOURS];
   logic [LABEL_W-1:0] label_in [NEIGHBOURS];
   logic               valid_ff [NEIGHBOURS];
   logic               valid_in [NEIGHBOURS];
   logic               ahead    [NEIGHBOURS];
   logic               admit;

   always_comb begin
      for (int i = 0; i < NEIGHBOURS; i++) begin
         ahead[i] = valid_ff[i] && (dist_ff[i] <= offer_dist_ff);
      end
      admit = offer_valid_ff && !ahead[NEIGHBOURS-1];

      for (int i = 0; i < NEIGHBOURS; i++) begin
         dist_in[i]  = dist_ff[i];
         label_in[i] = label_ff[i];
         valid_in[i] = valid_ff[i];
         if (cmd.shift) begin
            // move the list toward slot 0, refill the tail as empty
            if (i == NEIGHBOURS - 1) begin
               dist_in[i]  = ACC_MAX;
               label_in[i] = '0;
               valid_in[i] = 1'b0;
            end else begin
               dist_in[i]  = dist_ff[(i + 1) % NEIGHBOURS];
               label_in[i] = label_ff[(i + 1) % NEIGHBOURS];
               valid_in[i] = valid_ff[(i + 1) % NEIGHBOURS];
            end
         end else if (admit && !ahead[i]) begin
            if (i == 0 || ahead[(i + NEIGHBOURS - 1) % NEIGHBOURS]) begin
               dist_in[i]  = offer_dist_ff;
               label_in[i] = offer_label_ff;
               valid_in[i] = 1'b1;
            end else begin
               dist_in[i]  = dist_ff[(i + NEIGHBOURS - 1) % NEIGHBOURS];
               label_in[i] = label_ff[(i + NEIGHBOURS - 1) % NEIGHBOURS];
               valid_in[i] = valid_ff[(i + NEIGHBOURS - 1) % NEIGHBOURS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NEIGHBOURS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
         dist_ff[i]  <= dist_in[i];
         label_ff[i] <= label_in[i];
      end
   end

   // Output register and rank counter
   logic [SLOT_W-1:0]     rank_ff, rank_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]     rsp_rank_ff, rsp_rank_in;
   logic [OUT_DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [LABEL_W-1:0]    rsp_label_ff, rsp_label_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  at_last;

   always_comb begin
      at_last          = (rank_ff == SLOT_W'(NEIGHBOURS - 1));
      status.out_free  = !rsp_valid_ff || rsp_tready;
      status.last_rank = at_last;

      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rank_in  = rsp_rank_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_label_in = rsp_label_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.shift) begin
         rank_in      = at_last ? '0 : rank_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_rank_in  = RANK_W'(rank_ff);
         rsp_empty_in = !valid_ff[0];
         rsp_last_in  = at_last;
         if (!valid_ff[0]) begin
            rsp_dist_in  = '0;
            rsp_label_in = '0;
         end else begin
            rsp_dist_in  = (dist_ff[0] > ACC_W'(OUT_DIST_MAX)) ?
                           OUT_DIST_MAX : dist_ff[0][OUT_DIST_W-1:0];
            rsp_label_in = label_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rank_ff  <= rsp_rank_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_label_ff <= rsp_label_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rank               = rsp_rank_ff;
   assign neighbour_distance = rsp_dist_ff;
   assign neighbour_label    = rsp_label_ff;
   assign slot_empty         = rsp_empty_ff;
   assign last_of_run        = rsp_last_ff;

endmodule

@@ bench/knn_distance_topk_checker.sv @@
// Checker for knn_distance_topk_core: watches both stream channels, predicts
// the sorted neighbour list and compares every rsp beat. Depends on knn_pkg.
module knn_distance_topk_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [knn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [knn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output int                             fail_count,
   output int                             pending_results,
   output int                             results_checked
);
   import knn_pkg::*;

   typedef struct packed {
      logic [RANK_W-1:0]     rank;
      logic [OUT_DIST_W-1:0] distance;
      logic [LABEL_W-1:0]    label;
      logic                  empty;
      logic                  last;
   } neighbour_beat_type;

   neighbour_beat_type neighbour_queue[$];
   logic [ACC_W-1:0]   running_distance;
   logic [ACC_W-1:0]   near_dist  [NEIGHBOURS];
   logic [LABEL_W-1:0] near_label [NEIGHBOURS];
   logic               near_used  [NEIGHBOURS];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
   end

   function void clear_neighbours();
      for (int i = 0; i < NEIGHBOURS; i++) begin
         near_dist[i]  = ACC_MAX;
         near_label[i] = '0;
         near_used[i]  = 1'b0;
      end
   endfunction

   // Count a failure; tell the caller whether it may still be printed.
   function bit note_failure();
      fail_count++;
      return fail_count <= 10;
   endfunction

   always @(posedge clock) begin : watch
      neighbour_beat_type  seen, want;
      logic [PIXEL_W-1:0]  q, r, diff;
      logic [SQ_W-1:0]     sq;
      logic [ACC_W:0]      sum;
      logic [ACC_W-1:0]    d;
      logic [LABEL_W-1:0]  lab;
      int                  pos;
      if (reset) begin
         running_distance = '0;
         clear_neighbours();
         neighbour_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.rank     = rsp_tdata[RANK_W-1:0];
            seen.distance = rsp_tdata[RANK_W +: OUT_DIST_W];
            seen.label    = rsp_tdata[RANK_W+OUT_DIST_W +: LABEL_W];
            seen.empty    = rsp_tuser;
            seen.last     = rsp_tlast;
            if (neighbour_queue.size() == 0) begin
               if (note_failure())
                  $display("[%0t] unexpected rsp beat: rank %0d dist %0d label %0d",
                           $realtime, seen.rank, seen.distance, seen.label,
                           " empty %0b last %0b", seen.empty, seen.last);
            end else begin
               want = neighbour_queue.pop_front();
               results_checked++;
               if (seen !== want && note_failure()) begin
                  $display("[%0t] rsp mismatch: expected rank %0d dist %0d label %0d",
                           $realtime, want.rank, want.distance, want.label,
                           " empty %0b last %0b", want.empty, want.last);
                  $display("   got rank %0d dist %0d label %0d empty %0b last %0b",
                           seen.rank, seen.distance, seen.label, seen.empty,
                           seen.last);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            q    = req_tdata[7:0];
            r    = req_tdata[15:8];
            lab  = req_tdata[23:16];
            diff = (q > r) ? q - r : r - q;
            sq   = diff * diff;
            sum  = {1'b0, running_distance} + (ACC_W + 1)'(sq);
            running_distance = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];

            if (req_tlast || req_tuser) begin
               // Rank the closed image: strictly nearer than the worst entry,
               // placed after any entries of equal distance.
               d = running_distance;
               running_distance = '0;
               if (!(near_used[NEIGHBOURS-1] && !(d < near_dist[NEIGHBOURS-1]))) begin
                  pos = 0;
                  while (pos < NEIGHBOURS-1 && near_used[pos] && near_dist[pos] <= d)
                     pos++;
                  for (int i = NEIGHBOURS-1; i > pos; i--) begin
                     near_dist[i]  = near_dist[i-1];
                     near_label[i] = near_label[i-1];
                     near_used[i]  = near_used[i-1];
                  end
                  near_dist[pos]  = d;
                  near_label[pos] = lab;
                  near_used[pos]  = 1'b1;
               end
            end

            if (req_tuser) begin
               for (int k = 0; k < NEIGHBOURS; k++) begin
                  want.rank     = RANK_W'(k);
                  want.distance = !near_used[k] ? '0 :
                                  (near_dist[k] > OUT_DIST_MAX) ? OUT_DIST_MAX :
                                  near_dist[k][OUT_DIST_W-1:0];
                  want.label    = near_used[k] ? near_label[k] : '0;
                  want.empty    = !near_used[k];
                  want.last     = (k == NEIGHBOURS-1);
                  neighbour_queue.push_back(want);
               end
               clear_neighbours();
            end
         end
      end
      pending_results = neighbour_queue.size();
   end

endmodule

@@ bench/knn_distance_topk_core_tb.sv @@
// Testbench top for knn_distance_topk_core: drives pixel-pair beats with
// bursts and gaps, stalls the rsp side, and gives the verdict.
// Depends on knn_pkg, knn_distance_topk_core and knn_distance_topk_checker.
module knn_distance_topk_core_tb;
   import knn_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000; // cycles without any beat
   localparam int HOLD_OFF_CYCLES = 100;  // one long rsp stall
   localparam int RANDOM_BEATS    = 230;

   // How the last beat of an image closes it.
   typedef enum {
      CLOSE_IMAGE,     // image end only
      CLOSE_SET,       // image end and set end together
      CLOSE_SET_BARE   // set end without image end
   } close_kind_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   int fail_count;
   int pending_results;
   int results_checked;

   int beats_sent    = 0;
   int sets_sent     = 0;
   int directed_sets = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   bit hold_off_req  = 1'b0;
   bit hold_off_done = 1'b0;

   always #6 clock = ~clock;

   knn_distance_topk_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   knn_distance_topk_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .req_tuser       (req_tuser),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // Offer one pixel-pair beat and hold it until accepted. Called and left at a
   // falling edge. Between bursts drop tvalid for a random gap.
   task automatic send_beat(input logic [7:0] q, input logic [7:0] r,
                            input logic [7:0] label, input logic img_end,
                            input logic set_end);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         // Mostly short bursts, now and then a long unbroken stretch.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      req_tdata  <= {label, r, q};
      req_tlast  <= img_end;
      req_tuser  <= set_end;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      beats_sent++;
      if (set_end) sets_sent++;
   endtask

   // Stream an image whose pixels all hold the same pair.
   task automatic send_flat_image(input int pixels, input logic [7:0] q,
                                  input logic [7:0] r, input logic [7:0] label,
                                  input close_kind_type close);
      for (int p = 0; p < pixels; p++)
         send_beat(q, r, label, (p == pixels-1) && close != CLOSE_SET_BARE,
                   (p == pixels-1) && close != CLOSE_IMAGE);
   endtask

   // Stream one reference set of random shape. Narrow images keep the pixel
   // difference small so that distances collide and ties get exercised.
   task automatic send_random_set();
      int         images, pixels;
      bit         narrow, bare_end, last_pix, last_img;
      logic [7:0] base, q, r;
      images   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                             : $urandom_range(1, 10);
      bare_end = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < images; i++) begin
         pixels = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 16)
                                              : $urandom_range(1, 4);
         narrow = 1'($urandom_range(0, 1));
         for (int p = 0; p < pixels; p++) begin
            base     = 8'($urandom_range(0, 252));
            q        = narrow ? base + 8'($urandom_range(0, 3))
                              : 8'($urandom_range(0, 255));
            r        = narrow ? base + 8'($urandom_range(0, 3))
                              : 8'($urandom_range(0, 255));
            last_pix = (p == pixels-1);
            last_img = (i == images-1);
            send_beat(q, r, 8'($urandom_range(0, 255)),
                      last_pix && !(last_img && bare_end), last_pix && last_img);
         end
      end
   endtask

   // rsp side: stall on its own pattern, changing mode after each random stretch.
   // Once asked, hold off for a long stretch so the block backs up into req.
   initial begin : receiver
      int mode, stretch, held;
      held = 0;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(16, 64);
         repeat (stretch) begin
            @(negedge clock);
            if (hold_off_req && !hold_off_done) begin
               rsp_tready <= 1'b0;
               held++;
               if (held == HOLD_OFF_CYCLES) hold_off_done = 1'b1;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 3) != 0);
                  2: rsp_tready <= ($urandom_range(0, 2) == 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // End the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, pending_results);
         $display("knn_distance_topk_core_tb NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int random_start;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone image at the extreme pixel values: one entry, the rest empty.
      send_flat_image(1, 8'hFF, 8'h00, 8'hFF, CLOSE_SET);

      // Set end without image end still closes and ranks the open image.
      send_flat_image(2, 8'h01, 8'h00, 8'hA5, CLOSE_IMAGE);
      send_flat_image(3, 8'h00, 8'h02, 8'h5A, CLOSE_SET_BARE);

      // Ties: nine equal distances, the ninth must not displace the worst;
      // then an exact match jumps to the front and pushes the last one out.
      for (int i = 1; i <= 9; i++)
         send_flat_image(1, 8'd5, 8'd3, i[7:0], CLOSE_IMAGE);
      send_flat_image(1, 8'h80, 8'h80, 8'h00, CLOSE_IMAGE);
      send_flat_image(1, 8'd3, 8'd0, 8'hC3, CLOSE_SET);

      // Zero distance image and a bare set end right behind it.
      send_flat_image(1, 8'h00, 8'h00, 8'h00, CLOSE_IMAGE);
      send_flat_image(2, 8'h01, 8'h00, 8'h33, CLOSE_SET_BARE);
      directed_sets = sets_sent;

      // Random sets; the rsp side takes its long hold-off early on.
      hold_off_req = 1'b1;
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS)
         send_random_set();
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray beat.
      wait (pending_results == 0);
      repeat (NEIGHBOURS + 8) @(posedge clock);

      $display("covered %0d pixel beats in %0d reference sets (%0d directed)",
               beats_sent, sets_sent, directed_sets);
      $display("checked %0d neighbour beats, %0d failures, %0d left outstanding",
               results_checked, fail_count, pending_results);
      if (fail_count == 0 && pending_results == 0)
         $display("knn_distance_topk_core_tb OK");
      else
         $display("knn_distance_topk_core_tb NOT OK");
      $finish;
   end

endmodule
